// ===== hdl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Sequencer state type and state codes for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  typedef logic [2:0] state_t;

  localparam state_t ST_IDLE   = 3'd0;
  localparam state_t ST_REDUCE = 3'd1;
  localparam state_t ST_MUL    = 3'd2;
  localparam state_t ST_SQR    = 3'd3;
  localparam state_t ST_DONE   = 3'd4;

endpackage

// ===== hdl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base_value ** exponent mod modulus, right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Takes one item (base_value, exponent, modulus) and returns one power_result.
// A zero modulus gives 0; a zero exponent gives 1, unreduced. Every modular
// product goes through one shared bit-serial unit that takes one multiplier
// bit per cycle (double mod m, then add mod m). An item first reduces the
// base mod m in that unit, then does one multiply per set exponent bit and
// one square per bit below the highest set exponent bit; a zero modulus or
// exponent skips all of these. The input is stalled while an item is in
// work; a finished result waits in the output register and does not keep
// the next item from being taken in, though that item then waits in ST_DONE
// until the register is free.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPERAND_WIDTH-1:0] in_base_value,
  input  logic [OPERAND_WIDTH-1:0] in_exponent,
  input  logic [OPERAND_WIDTH-1:0] in_modulus,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OPERAND_WIDTH-1:0] out_power_result
);
  import mexp_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(OPERAND_WIDTH);

  state_t             state_r, state_nxt;
  logic [W-1:0]       base_r, base_nxt;
  logic [W-1:0]       exp_r, exp_nxt;
  logic [W-1:0]       mod_r, mod_nxt;
  logic [W-1:0]       res_r, res_nxt;
  logic [W-1:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [W-1:0]       out_data_r, out_data_nxt;

  // shared modular step: ((2*acc mod m) + (bit ? y : 0)) mod m, y <= m
  logic [W:0]   dbl, dbl_red, sum;
  logic [W-1:0] addend, step_out;
  logic         scan_bit;

  always_comb begin
    scan_bit = base_r[cnt_r];
    unique case (state_r)
      ST_REDUCE: addend = W'(1);
      ST_MUL:    addend = res_r;
      default:   addend = base_r;
    endcase
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, mod_r}) ? dbl - {1'b0, mod_r} : dbl;
    sum     = dbl_red + (scan_bit ? {1'b0, addend} : '0);
    step_out = (sum >= {1'b0, mod_r}) ? W'(sum - {1'b0, mod_r}) : W'(sum);
  end

  logic in_acc, out_acc, last_bit;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign last_bit = (cnt_r == '0);

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    mod_nxt       = mod_r;
    res_nxt       = res_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          base_nxt = in_base_value;
          exp_nxt  = in_exponent;
          mod_nxt  = in_modulus;
          acc_nxt  = '0;
          cnt_nxt  = CNT_W'(W - 1);
          // running result starts at 1, already reduced when modulus is 1
          res_nxt  = (in_modulus == W'(1)) ? '0 : W'(1);
          if (in_modulus == '0) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else if (in_exponent == '0) begin
            res_nxt   = W'(1);
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE, ST_MUL, ST_SQR: begin
        acc_nxt = step_out;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last_bit) begin
          acc_nxt = '0;
          cnt_nxt = CNT_W'(W - 1);
          unique case (state_r)
            ST_REDUCE: begin
              base_nxt  = step_out;
              state_nxt = exp_r[0] ? ST_MUL : ST_SQR;
            end
            ST_MUL: begin
              res_nxt   = step_out;
              state_nxt = (exp_r[W-1:1] == '0) ? ST_DONE : ST_SQR;
            end
            default: begin
              base_nxt  = step_out;
              exp_nxt   = exp_r >> 1;
              state_nxt = exp_r[1] ? ST_MUL : ST_SQR;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_acc) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    mod_r      <= mod_nxt;
    res_r      <= res_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_data_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modular exponentiation block.
// ----------------------------------------------------------------------------
// Sends (base, exponent, modulus) items through the valid/stall handshake and
// keeps a queue of predicted powers, computed with full double-width products.
// Directed corner items come first, then random items, mostly with short
// exponents. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 40;

  typedef logic [W-1:0] word_t;

  typedef struct {
    word_t base_value;
    word_t exponent;
    word_t modulus;
    word_t power;
  } power_item_t;

  class power_ledger;
    power_item_t powers_due[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // right-to-left square and multiply; 1 is left unreduced
    function word_t mod_power(word_t b, word_t e, word_t m);
      logic [2*W-1:0] acc;
      logic [2*W-1:0] sq;
      logic [2*W-1:0] mw;
      word_t bits;
      if (m == '0) begin
        return '0;
      end
      mw = {{W{1'b0}}, m};
      acc = (2*W)'(1);
      sq = {{W{1'b0}}, b} % mw;
      bits = e;
      while (bits != '0) begin
        if (bits[0]) begin
          acc = (acc * sq) % mw;
        end
        sq = (sq * sq) % mw;
        bits = bits >> 1;
      end
      return acc[W-1:0];
    endfunction

    function void note_operands(word_t b, word_t e, word_t m);
      power_item_t it;
      it.base_value = b;
      it.exponent = e;
      it.modulus = m;
      it.power = mod_power(b, e, m);
      powers_due = {powers_due, it};
    endfunction

    function void check_power(word_t actual);
      power_item_t it;
      if (powers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item: expected none, actual %h", $time, actual);
        return;
      end
      it = powers_due.pop_front();
      if (actual !== it.power) begin
        errors++;
        $display("%0t: power_result mismatch for %h ** %h mod %h: expected %h, actual %h",
                 $time, it.base_value, it.exponent, it.modulus, it.power, actual);
      end
    endfunction

    function int pending();
      return powers_due.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t in_base_value = '0;
  word_t in_exponent = '0;
  word_t in_modulus = '0;
  logic  out_valid;
  logic  out_stall = 1'b1;
  word_t out_power_result;

  power_ledger ledger = new();
  int cycle_count = 0;

  modular_exponentiation #(
    .OPERAND_WIDTH(W)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .in_exponent      (in_exponent),
    .in_modulus       (in_modulus),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, ledger.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called just after a rising edge. Leaves valid high so a zero gap gives
  // back-to-back items.
  task automatic send_operands(input word_t b, input word_t e, input word_t m,
                               input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base_value <= b;
    in_exponent <= e;
    in_modulus <= m;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    ledger.note_operands(b, e, m);
  endtask

  // Hold off the sender until every predicted power has come back.
  task automatic wait_all_returned();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  initial begin
    word_t b;
    word_t e;
    word_t m;
    int kind;
    int gap;
    bit quiet;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // corner cases
    send_operands(32'd5, 32'd3, 32'd13, 0);
    send_operands(32'd0, 32'd0, 32'd0, 0);              // zero modulus
    send_operands('1, '1, 32'd0, 3);                    // zero modulus, big operands
    send_operands(32'd12345678, 32'd0, 32'd0, 0);
    send_operands(32'd7, 32'd0, 32'd1, 0);              // zero exponent, modulus one
    send_operands(32'd7, 32'd5, 32'd1, 1);              // modulus one
    send_operands(32'd0, 32'd0, 32'd7, 0);              // zero exponent, zero base
    send_operands(32'd0, 32'd5, 32'd7, 0);
    send_operands('1, '1, '1, 2);
    send_operands('1, '1, 32'hFFFF_FFFB, 0);
    send_operands(32'd2, '1, 32'hFFFF_FFFB, 0);
    send_operands(32'hFFFF_FFFE, 32'd2, '1, 0);
    send_operands(32'd13, 32'd4, 32'd13, 5);            // base equals modulus
    send_operands(32'd100, 32'd3, 32'd7, 0);            // base above modulus
    send_operands('1, 32'd1, 32'hFFFF_FFFE, 0);
    send_operands(32'd3, 32'd200, 32'd2, 0);
    send_operands(32'd2, 32'd31, 32'h8000_0000, 0);
    send_operands(32'd1, '1, 32'd3, 0);
    send_operands(32'h0001_0001, 32'h0001_0001, 32'hFFFF_FFFB, 0);
    send_operands(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_operands(32'hDEAD_BEEF, 32'd1, 32'd65537, 0);
    wait_all_returned();

    quiet = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (i == 90 || i == 200) begin
        wait_all_returned();
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0:       m = $urandom_range(0, 1);
        1, 2, 3: m = $urandom_range(2, 255);
        4, 5:    m = $urandom_range(256, 65535);
        default: m = $urandom();
      endcase
      b = ($urandom_range(0, 9) < 7) ? word_t'($urandom()) : word_t'($urandom_range(0, 3));
      kind = $urandom_range(0, 9);
      // long exponents are slow, so most stay short
      if (kind == 0) begin
        e = '0;
      end else if (kind <= 2) begin
        e = $urandom();
      end else begin
        e = $urandom() >> $urandom_range(8, 31);
      end
      gap = quiet ? 0 : $urandom_range(0, 17);
      send_operands(b, e, m, gap);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (ledger.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stall, sometimes held until the result shows up
  initial begin
    word_t actual;
    int hold;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    repeat (11) @(posedge clk);
    forever begin
      if (taken % 30 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      hold = quiet ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 1) == 1) begin
          do @(negedge clk); while (!out_valid);
        end
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      actual = out_power_result;
      @(posedge clk);
      ledger.check_power(actual);
      taken++;
    end
  end

endmodule
